// ===== hdl/lsbmu_pkg.sv =====
package lsbmu_pkg;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam int unsigned NUM_BANKS = 4;

    typedef struct packed {
        logic        action;
        logic [1:0]  access_size;
        logic        sign_extend;
        logic [31:0] base_address;
        logic [31:0] offset;
        logic [31:0] store_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] load_data;
        logic        fault;
    } t_out_item;

endpackage

// ===== hdl/load_store_byte_memory_unit.sv =====
// Byte, halfword and word loads and stores over a little-endian byte memory of
// MEM_BYTES bytes, held in four byte-wide banks (byte address modulo four
// picks the bank) so that any unaligned access of up to four bytes touches
// each bank at most once. After reset a clearing pass writes zero to every
// bank row, one row per cycle, ceil(MEM_BYTES/4) rows in all; no item is taken
// meanwhile. Each item then passes, in order, through address add, range
// check of each byte with bank mapping, one bank access that returns the read
// data, and result formatting into the output register.
// One item is in work at a time and the next item is taken in the cycle after
// the result is loaded; the next item is taken while a finished result waits
// to be taken, and a further one waits until that result leaves.
// Any byte at or beyond MEM_BYTES raises fault; a faulting store still
// writes the bytes before the first faulting one, a faulting load returns zero.
module load_store_byte_memory_unit #(
    parameter int unsigned MEM_BYTES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lsbmu_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lsbmu_pkg::t_out_item o_out_item
);
    import lsbmu_pkg::*;

    localparam int unsigned BANK_DEPTH = (MEM_BYTES + 3) / 4;
    localparam int unsigned BI_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);
    localparam logic [BI_W-1:0] CLR_LAST = BI_W'(BANK_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SUM    = 6'b000100,
        S_CHECK  = 6'b001000,
        S_ACCESS = 6'b010000,
        S_DATA   = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [BI_W-1:0] r_clr_idx, n_clr_idx;
    t_in_item        r_item;
    logic [31:0]     r_addr;
    logic            r_fault, n_fault;
    logic [3:0]      r_bank_en, n_bank_en;
    logic [BI_W-1:0] r_bank_idx [NUM_BANKS];
    logic [BI_W-1:0] n_bank_idx [NUM_BANKS];
    logic [7:0]      r_bank_wd [NUM_BANKS];
    logic [7:0]      n_bank_wd [NUM_BANKS];
    logic [7:0]      r_rd [NUM_BANKS];
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_item;

    logic            mem_en [NUM_BANKS];
    logic            mem_we [NUM_BANKS];
    logic [BI_W-1:0] mem_idx [NUM_BANKS];
    logic [7:0]      mem_wd [NUM_BANKS];

    logic            in_take;
    logic            out_load;
    logic [2:0]      nbytes;
    logic [31:0]     byte_addr [NUM_BANKS];
    logic [3:0]      byte_flt;
    logic [3:0]      byte_en;
    logic [1:0]      bsel;
    logic            seen_flt;
    logic [31:0]     value;
    logic [1:0]      rsel;

    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_DATA) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // state and clearing pass
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + BI_W'(1);
                if (r_clr_idx == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_SUM;
                end
            end
            S_SUM:    n_state = S_CHECK;
            S_CHECK:  n_state = S_ACCESS;
            S_ACCESS: n_state = S_DATA;
            S_DATA: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // per byte range check and bank mapping
    always_comb begin
        case (r_item.access_size)
            SIZE_BYTE: nbytes = 3'd1;
            SIZE_HALF: nbytes = 3'd2;
            default:   nbytes = 3'd4;
        endcase
        seen_flt  = 1'b0;
        n_fault   = 1'b0;
        n_bank_en = '0;
        bsel      = '0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            n_bank_idx[i] = '0;
            n_bank_wd[i]  = '0;
        end
        for (int i = 0; i < NUM_BANKS; i++) begin
            byte_addr[i] = r_addr + 32'(i);
            byte_flt[i]  = (byte_addr[i] >= MEM_LIMIT);
            byte_en[i]   = (3'(i) < nbytes) && !byte_flt[i] && !seen_flt;
            if ((3'(i) < nbytes) && byte_flt[i]) begin
                seen_flt = 1'b1;
                n_fault  = 1'b1;
            end
            bsel             = r_addr[1:0] + 2'(i);
            n_bank_en[bsel]  = byte_en[i];
            n_bank_idx[bsel] = byte_addr[i][BI_W+1:2];
            n_bank_wd[bsel]  = r_item.store_data[8*i +: 8];
        end
    end

    // result formatting
    always_comb begin
        value = '0;
        rsel  = '0;
        for (int i = 0; i < NUM_BANKS; i++) begin
            rsel = r_addr[1:0] + 2'(i);
            if (r_bank_en[rsel]) begin
                value[8*i +: 8] = r_rd[rsel];
            end
        end
        if (r_item.action == ACT_STORE || r_fault) begin
            value = '0;
        end else if (r_item.sign_extend) begin
            if (r_item.access_size == SIZE_BYTE && value[7]) begin
                value[31:8] = '1;
            end else if (r_item.access_size == SIZE_HALF && value[15]) begin
                value[31:16] = '1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_item;
        end
        if (r_state == S_SUM) begin
            r_addr <= r_item.base_address + r_item.offset;
        end
        if (r_state == S_CHECK) begin
            r_fault    <= n_fault;
            r_bank_en  <= n_bank_en;
            r_bank_idx <= n_bank_idx;
            r_bank_wd  <= n_bank_wd;
        end
        if (out_load) begin
            r_out_item.load_data <= value;
            r_out_item.fault     <= r_fault;
        end
    end

    // bank port controls
    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (r_state == S_CLEAR) begin
                mem_en[b]  = 1'b1;
                mem_we[b]  = 1'b1;
                mem_idx[b] = r_clr_idx;
                mem_wd[b]  = '0;
            end else begin
                mem_en[b]  = (r_state == S_ACCESS) && r_bank_en[b];
                mem_we[b]  = (r_state == S_ACCESS) && r_bank_en[b]
                             && (r_item.action == ACT_STORE);
                mem_idx[b] = r_bank_idx[b];
                mem_wd[b]  = r_bank_wd[b];
            end
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        always_ff @(posedge i_clk) begin
            if (mem_we[b]) begin
                mem[mem_idx[b]] <= mem_wd[b];
            end else if (mem_en[b]) begin
                r_rd[b] <= mem[mem_idx[b]];
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import lsbmu_pkg::*;

    localparam int unsigned MEM_BYTES      = 65536;
    localparam int          RANDOM_ITEMS   = 700;
    localparam int          WATCHDOG_LIMIT = 100000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          HOLD_AT_ITEM   = 430;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          MAX_PRINTS     = 50;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    logic [7:0] mem_image [0:MEM_BYTES-1];

    int n_accepted = 0;
    int n_errors = 0;
    int hold_left = 0;
    bit held_off = 1'b0;
    int quiet_cycles = 0;

    load_store_byte_memory_unit #(
        .MEM_BYTES(MEM_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out_item lsu_access(input t_in_item it);
        logic [31:0] eff_addr;
        logic [31:0] byte_addr;
        logic [31:0] value;
        logic        faulted;
        int          nbytes;
        t_out_item   res;
        eff_addr = it.base_address + it.offset;
        case (it.access_size)
            SIZE_BYTE: nbytes = 1;
            SIZE_HALF: nbytes = 2;
            default:   nbytes = 4;
        endcase
        value = '0;
        faulted = 1'b0;
        for (int i = 0; i < nbytes; i++) begin
            byte_addr = eff_addr + i;
            if (!faulted) begin
                if (byte_addr >= MEM_BYTES) begin
                    faulted = 1'b1;
                end else if (it.action == ACT_STORE) begin
                    mem_image[byte_addr] = it.store_data[8*i +: 8];
                end else begin
                    value[8*i +: 8] = mem_image[byte_addr];
                end
            end
        end
        if (it.action == ACT_STORE || faulted) begin
            value = '0;
        end else if (it.sign_extend) begin
            if (nbytes == 1 && value[7]) begin
                value[31:8] = '1;
            end else if (nbytes == 2 && value[15]) begin
                value[31:16] = '1;
            end
        end
        res.load_data = value;
        res.fault = faulted;
        return res;
    endfunction

    function automatic t_in_item mk_access(input logic act, input logic [1:0] size,
                                           input logic sext, input logic [31:0] base,
                                           input logic [31:0] off, input logic [31:0] data);
        t_in_item it;
        it.action = act;
        it.access_size = size;
        it.sign_extend = sext;
        it.base_address = base;
        it.offset = off;
        it.store_data = data;
        return it;
    endfunction

    function automatic t_in_item random_access();
        t_in_item    it;
        logic [31:0] target;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            target = $urandom_range(0, 47);
        end else if (pick < 85) begin
            target = MEM_BYTES - 8 + $urandom_range(0, 7);
        end else if (pick < 92) begin
            target = 32'hFFFF_FFFC + $urandom_range(0, 3);
        end else begin
            target = $urandom();
        end
        it.base_address = $urandom();
        it.offset = target - it.base_address;
        it.action = ($urandom_range(0, 99) < 45) ? ACT_STORE : ACT_LOAD;
        it.access_size = 2'($urandom_range(0, 3));
        it.sign_extend = 1'($urandom_range(0, 1));
        it.store_data = $urandom();
        return it;
    endfunction

    // idle percentage per phase: none, sender, receiver, both
    function automatic int gap_percent(input bit for_sender);
        case ((n_accepted / 100) % 4)
            1:       return for_sender ? 46 : 0;
            2:       return for_sender ? 0 : 46;
            3:       return 35;
            default: return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (n_errors < MAX_PRINTS) begin
            $display("tb_top: mismatch %s: expected %h got %h", what, want, got);
        end
        n_errors++;
    endtask

    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= gap_percent(1'b1)) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!held_off && n_accepted >= HOLD_AT_ITEM) begin
            held_off <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < gap_percent(1'b0));
        end
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", '0, out_item.load_data);
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.load_data !== want.load_data)
                        report_mismatch("load_data", want.load_data, out_item.load_data);
                    if (out_item.fault !== want.fault)
                        report_mismatch("fault", 32'(want.fault), 32'(out_item.fault));
                end
            end
            if (in_valid && !in_stall) begin
                expected_results.push_back(lsu_access(in_item));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MEM_BYTES; i++) mem_image[i] = 8'h00;

        // sign and zero extension over a known word
        pending_items.push_back(mk_access(ACT_STORE, SIZE_WORD, 1'b1, 32'h0, 32'h0, 32'h80FF_7F01));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_WORD, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b1, 32'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b1, 32'h1, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b1, 32'h0, 32'h2, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b0, 32'h2, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_HALF, 1'b1, 32'h2, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_HALF, 1'b0, 32'h2, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_HALF, 1'b1, 32'hFFFF_FFFF, 32'h2,
                                          32'h0));
        // faults at the top of memory and across the 2^32 wrap
        pending_items.push_back(mk_access(ACT_STORE, SIZE_HALF, 1'b0, 32'hFFFF_FFFF,
                                          32'h0001_0000, 32'hA5A5_1234));
        pending_items.push_back(mk_access(ACT_STORE, SIZE_WORD, 1'b0, 32'h0001_0000,
                                          32'hFFFF_FFFD, 32'hCAFE_F00D));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_WORD, 1'b0, 32'h0000_FFFC, 32'h0,
                                          32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_WORD, 1'b1, 32'h0000_FFFD, 32'h0,
                                          32'h0));
        pending_items.push_back(mk_access(ACT_STORE, SIZE_WORD, 1'b0, 32'hFFFF_FFFF, 32'h0,
                                          32'h1122_3344));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_WORD, 1'b0, 32'h0, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_STORE, SIZE_BYTE, 1'b1, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b1, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF, 32'h0));
        // size code three acts as a word
        pending_items.push_back(mk_access(ACT_STORE, 2'd3, 1'b0, 32'h8, 32'h0, 32'hDEAD_BEEF));
        pending_items.push_back(mk_access(ACT_LOAD, 2'd3, 1'b1, 32'h0, 32'h8, 32'h0));
        pending_items.push_back(mk_access(ACT_STORE, SIZE_BYTE, 1'b0, 32'h10, 32'h0,
                                          32'hFFFF_FFFF));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_BYTE, 1'b0, 32'h10, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_WORD, 1'b1, 32'h20, 32'h0, 32'h0));
        pending_items.push_back(mk_access(ACT_STORE, SIZE_WORD, 1'b0, 32'h0000_FFFC, 32'h0,
                                          32'h8765_4321));
        pending_items.push_back(mk_access(ACT_LOAD, SIZE_HALF, 1'b1, 32'h0000_FFFE, 32'h0,
                                          32'h0));
        for (int i = 0; i < RANDOM_ITEMS; i++) pending_items.push_back(random_access());

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
